// ----- hw/rtl/m4inv_pkg.sv -----
// m4inv_pkg: widths, fixed-point format and index tables for the 4x4 inverse.
// Used by matrix4_inverse; depends on nothing.
package m4inv_pkg;

    localparam int ELEM_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int PAIR_W    = 64;
    localparam int COF_W     = 100;
    localparam int DET_W     = 134;
    localparam int MUL_A_W   = 37;
    localparam int MUL_B_W   = 33;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int NUM_W     = COF_W + 2 * FRAC_BITS;
    localparam int QB        = 33;
    localparam int Q_W       = QB + 1;
    localparam int DVS_W     = DET_W + QB;

    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_PAIR  = 9'b000000010,
        S_COF   = 9'b000000100,
        S_DET   = 9'b000001000,
        S_DSET  = 9'b000010000,
        S_DCHK  = 9'b000100000,
        S_DITER = 9'b001000000,
        S_DRND  = 9'b010000000,
        S_DEMIT = 9'b100000000
    } t_state;

    // operand indices (into the transposed matrix) of the 24 pair products
    localparam logic [3:0] PAIR_A [24] = '{
        4'd10, 4'd11, 4'd9, 4'd11, 4'd9, 4'd10, 4'd8, 4'd11, 4'd8, 4'd10, 4'd8, 4'd9,
        4'd2, 4'd3, 4'd1, 4'd3, 4'd1, 4'd2, 4'd0, 4'd3, 4'd0, 4'd2, 4'd0, 4'd1};
    localparam logic [3:0] PAIR_B [24] = '{
        4'd15, 4'd14, 4'd15, 4'd13, 4'd14, 4'd13, 4'd15, 4'd12, 4'd14, 4'd12, 4'd13,
        4'd12, 4'd7, 4'd6, 4'd7, 4'd5, 4'd6, 4'd5, 4'd7, 4'd4, 4'd6, 4'd4, 4'd5, 4'd4};

    // per cofactor six terms: first three added, last three subtracted
    localparam logic [4:0] COF_P [96] = '{
        5'd0, 5'd3, 5'd4, 5'd1, 5'd2, 5'd5,
        5'd1, 5'd6, 5'd9, 5'd0, 5'd7, 5'd8,
        5'd2, 5'd7, 5'd10, 5'd3, 5'd6, 5'd11,
        5'd5, 5'd8, 5'd11, 5'd4, 5'd9, 5'd10,
        5'd1, 5'd2, 5'd5, 5'd0, 5'd3, 5'd4,
        5'd0, 5'd7, 5'd8, 5'd1, 5'd6, 5'd9,
        5'd3, 5'd6, 5'd11, 5'd2, 5'd7, 5'd10,
        5'd4, 5'd9, 5'd10, 5'd5, 5'd8, 5'd11,
        5'd12, 5'd15, 5'd16, 5'd13, 5'd14, 5'd17,
        5'd13, 5'd18, 5'd21, 5'd12, 5'd19, 5'd20,
        5'd14, 5'd19, 5'd22, 5'd15, 5'd18, 5'd23,
        5'd17, 5'd20, 5'd23, 5'd16, 5'd21, 5'd22,
        5'd14, 5'd17, 5'd13, 5'd16, 5'd12, 5'd15,
        5'd20, 5'd12, 5'd19, 5'd18, 5'd21, 5'd13,
        5'd18, 5'd23, 5'd15, 5'd22, 5'd14, 5'd19,
        5'd22, 5'd16, 5'd21, 5'd20, 5'd23, 5'd17};
    localparam logic [3:0] COF_S [96] = '{
        4'd5, 4'd6, 4'd7, 4'd5, 4'd6, 4'd7,
        4'd4, 4'd6, 4'd7, 4'd4, 4'd6, 4'd7,
        4'd4, 4'd5, 4'd7, 4'd4, 4'd5, 4'd7,
        4'd4, 4'd5, 4'd6, 4'd4, 4'd5, 4'd6,
        4'd1, 4'd2, 4'd3, 4'd1, 4'd2, 4'd3,
        4'd0, 4'd2, 4'd3, 4'd0, 4'd2, 4'd3,
        4'd0, 4'd1, 4'd3, 4'd0, 4'd1, 4'd3,
        4'd0, 4'd1, 4'd2, 4'd0, 4'd1, 4'd2,
        4'd13, 4'd14, 4'd15, 4'd13, 4'd14, 4'd15,
        4'd12, 4'd14, 4'd15, 4'd12, 4'd14, 4'd15,
        4'd12, 4'd13, 4'd15, 4'd12, 4'd13, 4'd15,
        4'd12, 4'd13, 4'd14, 4'd12, 4'd13, 4'd14,
        4'd10, 4'd11, 4'd9, 4'd11, 4'd9, 4'd10,
        4'd11, 4'd8, 4'd10, 4'd10, 4'd11, 4'd8,
        4'd9, 4'd11, 4'd8, 4'd11, 4'd8, 4'd9,
        4'd10, 4'd8, 4'd9, 4'd9, 4'd10, 4'd8};

endpackage

// ----- hw/rtl/matrix4_inverse.sv -----
// matrix4_inverse: 4x4 fixed-point matrix inverse by cofactors on one shared
// multiplier and a restoring divider. Depends on m4inv_pkg.
//
//  port group   dir  fields (low bit up)                       accepted when
//  s_axis_*     in   tdata: element_value[31:0]                tvalid & tready
//  m_axis_*     out  tdata: inverse_value[31:0], tuser:        tvalid & tready
//                    singular, tlast: last_of_run
//
// Words 1-15 fill the store. Word 16 starts the compute: pair products, cofactor
// terms and determinant terms on the one 37x33 multiplier, then for each output
// a divide of 33 divider steps; a singular matrix skips the divider for each
// output.
// tready is low from word 16 until the last result is in the output register.
// A stalled output holds the sequencer. Reset clears control, not the store.
module matrix4_inverse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [m4inv_pkg::ELEM_W-1:0]  s_axis_tdata,   // element_value
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [m4inv_pkg::ELEM_W-1:0]  m_axis_tdata,   // inverse_value
    output logic                          m_axis_tuser,   // singular
    output logic                          m_axis_tlast    // last_of_run
);
    import m4inv_pkg::*;

    t_state                     r_state;
    logic [3:0]                 r_cnt;
    logic                       r_sub;
    logic [4:0]                 r_idx;
    logic [3:0]                 r_term;
    logic [ELEM_W-1:0]          r_store [16];
    logic [PAIR_W-1:0]          r_pp    [24];
    logic [COF_W-1:0]           r_cof   [16];
    logic [ELEM_W-1:0]          r_opa;
    logic signed [PROD_W-1:0]   r_prod;
    logic [1:0]                 r_sh;
    logic                       r_neg;
    logic [DET_W-1:0]           r_acc;
    logic [DET_W-1:0]           r_det;
    logic [NUM_W-1:0]           r_rem;
    logic [DET_W-1:0]           r_dabs;
    logic [DVS_W-1:0]           r_dsh;
    logic [Q_W-1:0]             r_q;
    logic [5:0]                 r_bit;
    logic                       r_negres;
    logic                       r_ovf;
    logic                       r_sing;
    logic                       r_ovalid;
    logic [ELEM_W-1:0]          r_odata;
    logic                       r_osing;
    logic                       r_olast;

    logic [3:0]                 src_j;
    logic [ELEM_W-1:0]          st_rd;
    logic [6:0]                 ci;
    logic [PAIR_W-1:0]          pp_rd;
    logic [COF_W-1:0]           cof_rd;
    logic [MUL_A_W-1:0]         mul_a;
    logic signed [PROD_W-1:0]   mul_p;
    logic [DET_W-1:0]           acc_base;
    logic [DET_W-1:0]           acc_term;
    logic [DET_W-1:0]           acc_next;
    logic [NUM_W-1:0]           num;
    logic [NUM_W-1:0]           num_abs;
    logic [DET_W-1:0]           det_abs;
    logic [DVS_W-1:0]           rem_ext;
    logic                       div_ge;
    logic [ELEM_W-1:0]          res_val;
    logic                       out_free;
    logic                       in_acc;

    assign s_axis_tready = (r_state == S_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;

    assign ci = 7'(r_idx[3:0]) * 7'd6 + 7'(r_term[3:1]);

    always_comb begin
        unique case (r_state)
            S_PAIR:  src_j = r_sub ? PAIR_B[r_idx] : PAIR_A[r_idx];
            S_COF:   src_j = COF_S[ci];
            S_DET:   src_j = r_idx[3:0];
            default: src_j = 4'd0;
        endcase
    end

    // transposed read
    assign st_rd  = r_store[{src_j[1:0], src_j[3:2]}];
    assign pp_rd  = r_pp[COF_P[ci]];
    assign cof_rd = r_cof[r_idx[3:0]];

    always_comb begin
        if (r_state == S_PAIR) begin
            mul_a = {{(MUL_A_W-ELEM_W){r_opa[ELEM_W-1]}}, r_opa};
        end else if (r_state == S_COF) begin
            mul_a = r_term[0] ? {{(MUL_A_W-32){pp_rd[63]}}, pp_rd[63:32]}
                              : {{(MUL_A_W-32){1'b0}}, pp_rd[31:0]};
        end else begin
            unique case (r_term[1:0])
                2'd0:    mul_a = {{(MUL_A_W-32){1'b0}}, cof_rd[31:0]};
                2'd1:    mul_a = {{(MUL_A_W-32){1'b0}}, cof_rd[63:32]};
                default: mul_a = {{(MUL_A_W-COF_W+64){cof_rd[COF_W-1]}},
                                  cof_rd[COF_W-1:64]};
            endcase
        end
    end

    assign mul_p = $signed(mul_a) * $signed({st_rd[ELEM_W-1], st_rd});

    assign acc_term = {{(DET_W-PROD_W){r_prod[PROD_W-1]}}, r_prod} << {r_sh, 5'b0};
    assign acc_next = r_neg ? acc_base - acc_term : acc_base + acc_term;

    always_comb begin
        if (r_state == S_COF) begin
            acc_base = (r_term == 4'd0) ? '0 : r_acc;
        end else begin
            acc_base = (r_idx == 5'd0 && r_term == 4'd0) ? '0 : r_acc;
        end
    end

    assign num     = {cof_rd, {(2*FRAC_BITS){1'b0}}};
    assign num_abs = num[NUM_W-1] ? (~num + 1'b1) : num;
    assign det_abs = r_det[DET_W-1] ? (~r_det + 1'b1) : r_det;
    assign rem_ext = DVS_W'(r_rem);
    assign div_ge  = rem_ext >= r_dsh;

    always_comb begin
        if (r_sing) begin
            res_val = '0;
        end else if (r_ovf) begin
            res_val = r_negres ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (!r_negres) begin
            res_val = (r_q > Q_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r_q[31:0];
        end else begin
            res_val = (r_q > Q_W'(32'h8000_0000)) ? 32'h8000_0000 : (~r_q[31:0] + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_store[r_cnt] <= s_axis_tdata;
        end
        if (r_state == S_PAIR && r_sub) begin
            r_pp[r_idx] <= mul_p[PAIR_W-1:0];
        end
        if (r_state == S_PAIR && !r_sub) begin
            r_opa <= st_rd;
        end
        if ((r_state == S_COF || r_state == S_DET) && !r_sub) begin
            r_prod <= mul_p;
            r_sh   <= (r_state == S_COF) ? {1'b0, r_term[0]} : r_term[1:0];
            r_neg  <= (r_state == S_COF) && (r_term[3:1] >= 3'd3);
        end
        if ((r_state == S_COF || r_state == S_DET) && r_sub) begin
            r_acc <= acc_next;
        end
        if (r_state == S_COF && r_sub && r_term == 4'd11) begin
            r_cof[r_idx[3:0]] <= acc_next[COF_W-1:0];
        end
        if (r_state == S_DET && r_sub && r_term == 4'd2 && r_idx == 5'd3) begin
            r_det <= acc_next;
        end
        unique case (r_state)
            S_DSET: begin
                r_rem    <= num_abs;
                r_dabs   <= det_abs;
                r_negres <= cof_rd[COF_W-1] ^ r_det[DET_W-1];
                r_sing   <= (r_det == '0);
                r_ovf    <= 1'b0;
                r_q      <= '0;
            end
            S_DCHK: begin
                r_ovf <= rem_ext >= {r_dabs, {QB{1'b0}}};
                r_dsh <= DVS_W'({r_dabs, {(QB-1){1'b0}}});
                r_bit <= 6'(QB - 1);
            end
            S_DITER: begin
                if (div_ge) begin
                    r_rem <= NUM_W'(rem_ext - r_dsh);
                end
                r_q   <= {r_q[Q_W-2:0], div_ge};
                r_dsh <= r_dsh >> 1;
                r_bit <= r_bit - 6'd1;
            end
            S_DRND: begin
                if (DVS_W'({r_rem, 1'b0}) >= DVS_W'(r_dabs)) begin
                    r_q <= r_q + 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (r_state == S_DEMIT && out_free) begin
            r_odata <= res_val;
            r_osing <= r_sing;
            r_olast <= (r_idx == 5'd15);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_sub    <= 1'b0;
            r_idx    <= '0;
            r_term   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DEMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_cnt <= r_cnt + 4'd1;
                        if (r_cnt == 4'd15) begin
                            r_state <= S_PAIR;
                            r_idx   <= '0;
                            r_sub   <= 1'b0;
                        end
                    end
                end
                S_PAIR: begin
                    r_sub <= !r_sub;
                    if (r_sub) begin
                        if (r_idx == 5'd23) begin
                            r_state <= S_COF;
                            r_idx   <= '0;
                            r_term  <= '0;
                        end else begin
                            r_idx <= r_idx + 5'd1;
                        end
                    end
                end
                S_COF: begin
                    r_sub <= !r_sub;
                    if (r_sub) begin
                        if (r_term == 4'd11) begin
                            r_term <= '0;
                            if (r_idx == 5'd15) begin
                                r_state <= S_DET;
                                r_idx   <= '0;
                            end else begin
                                r_idx <= r_idx + 5'd1;
                            end
                        end else begin
                            r_term <= r_term + 4'd1;
                        end
                    end
                end
                S_DET: begin
                    r_sub <= !r_sub;
                    if (r_sub) begin
                        if (r_term == 4'd2) begin
                            r_term <= '0;
                            if (r_idx == 5'd3) begin
                                r_state <= S_DSET;
                                r_idx   <= '0;
                            end else begin
                                r_idx <= r_idx + 5'd1;
                            end
                        end else begin
                            r_term <= r_term + 4'd1;
                        end
                    end
                end
                S_DSET:  r_state <= (r_det == '0) ? S_DEMIT : S_DCHK;
                S_DCHK:  r_state <= S_DITER;
                S_DITER: begin
                    if (r_bit == 6'd0) begin
                        r_state <= S_DRND;
                    end
                end
                S_DRND:  r_state <= S_DEMIT;
                S_DEMIT: begin
                    if (out_free) begin
                        if (r_idx == 5'd15) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + 5'd1;
                            r_state <= S_DSET;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_osing;
    assign m_axis_tlast  = r_olast;

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_cnt == 4'd15 |=> r_state == S_PAIR)
        else $error("sixteenth word did not start the compute");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_osing |-> r_odata == '0)
        else $error("singular result carries nonzero data");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DEMIT && !out_free |=> r_state == S_DEMIT && $stable(r_idx))
        else $error("result index moved while output stalled");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DEMIT && out_free && r_idx == 5'd15 |=> r_olast && r_ovalid)
        else $error("last result not marked");

endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking bench for matrix4_inverse, 4x4 fixed-point inverse.
// Holds its own wide-integer cofactor predictor; depends on the RTL and m4inv_pkg.
module tb_top;

    typedef logic signed [199:0] wide_t;
    typedef struct packed {
        logic [31:0] value;
        logic        singular;
        logic        last;
    } inv_word_t;

    localparam int FRAC = m4inv_pkg::FRAC_BITS;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD = 1500;

    // pair products of the transposed matrix: low half rows, high half rows
    localparam int LO_A [12] = '{10, 11, 9, 11, 9, 10, 8, 11, 8, 10, 8, 9};
    localparam int LO_B [12] = '{15, 14, 15, 13, 14, 13, 15, 12, 14, 12, 13, 12};
    localparam int HI_A [12] = '{2, 3, 1, 3, 1, 2, 0, 3, 0, 2, 0, 1};
    localparam int HI_B [12] = '{7, 6, 7, 5, 6, 5, 7, 4, 6, 4, 5, 4};
    // per cofactor: (pair, element) x3 added, then x3 subtracted
    localparam int COF_TERMS [192] = '{
        0,5, 3,6, 4,7,    1,5, 2,6, 5,7,
        1,4, 6,6, 9,7,    0,4, 7,6, 8,7,
        2,4, 7,5, 10,7,   3,4, 6,5, 11,7,
        5,4, 8,5, 11,6,   4,4, 9,5, 10,6,
        1,1, 2,2, 5,3,    0,1, 3,2, 4,3,
        0,0, 7,2, 8,3,    1,0, 6,2, 9,3,
        3,0, 6,1, 11,3,   2,0, 7,1, 10,3,
        4,0, 9,1, 10,2,   5,0, 8,1, 11,2,
        0,13, 3,14, 4,15,   1,13, 2,14, 5,15,
        1,12, 6,14, 9,15,   0,12, 7,14, 8,15,
        2,12, 7,13, 10,15,  3,12, 6,13, 11,15,
        5,12, 8,13, 11,14,  4,12, 9,13, 10,14,
        2,10, 5,11, 1,9,    4,11, 0,9, 3,10,
        8,11, 0,8, 7,10,    6,10, 9,11, 1,8,
        6,9, 11,11, 3,8,    10,11, 2,8, 7,9,
        10,10, 4,8, 9,9,    8,9, 11,10, 5,8};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // element_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // inverse_value
    logic        m_axis_tuser;        // singular
    logic        m_axis_tlast;        // last_of_run

    logic [31:0] matrix [16];
    int          load_pos = 0;
    inv_word_t   inverse_q [$];
    int          fail_count = 0;
    int          hold_cycles = 0;
    int          hold_req = 0;
    int          hold_ack = 0;
    bit          quiet = 1'b0;
    int          idle_count = 0;

    matrix4_inverse i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void predict_inverse();
        wide_t       src [16];
        wide_t       plo [12];
        wide_t       phi [12];
        wide_t       cof [16];
        wide_t       det, acc, t, num;
        logic [199:0] an, ad, q, r;
        logic        neg;
        inv_word_t   w;
        for (int i = 0; i < 16; i++)
            src[(i % 4) * 4 + i / 4] = {{168{matrix[i][31]}}, matrix[i]};
        for (int i = 0; i < 12; i++) begin
            plo[i] = src[LO_A[i]] * src[LO_B[i]];
            phi[i] = src[HI_A[i]] * src[HI_B[i]];
        end
        for (int i = 0; i < 16; i++) begin
            acc = '0;
            for (int k = 0; k < 6; k++) begin
                t = (i < 8) ? plo[COF_TERMS[i*12+2*k]] : phi[COF_TERMS[i*12+2*k]];
                t = t * src[COF_TERMS[i*12+2*k+1]];
                acc = (k < 3) ? acc + t : acc - t;
            end
            cof[i] = acc;
        end
        det = '0;
        for (int i = 0; i < 4; i++) det = det + src[i] * cof[i];
        for (int i = 0; i < 16; i++) begin
            w.last = (i == 15);
            w.singular = (det == 0);
            w.value = '0;
            if (det != 0) begin
                num = cof[i] <<< (2 * FRAC);
                neg = num[199] ^ det[199];
                an = num[199] ? -num : num;
                ad = det[199] ? -det : det;
                q = an / ad;
                r = an % ad;
                if ((r << 1) >= ad) q = q + 1;
                if (neg) w.value = (q > 200'h80000000) ? 32'h80000000 : -q[31:0];
                else     w.value = (q > 200'h7fffffff) ? 32'h7fffffff : q[31:0];
            end
            inverse_q.push_back(w);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(input logic [31:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        matrix[load_pos] = v;
        load_pos = (load_pos + 1) % 16;
        if (load_pos == 0) predict_inverse();
    endtask

    task automatic send_matrix(input logic [31:0] m [16]);
        for (int i = 0; i < 16; i++) send_word(m[i]);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random ready, occasional long stalls, forced stall on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_cycles <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 299) == 0) begin
            hold_cycles <= $urandom_range(20, 80);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 9) > 2);
        end
    end

    always @(posedge i_clk) begin
        inv_word_t exp_w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (inverse_q.size() == 0) begin
                $display("%0t: unexpected word %h/%b/%b", $time,
                         m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fail_count++;
            end else begin
                exp_w = inverse_q.pop_front();
                if (exp_w.value !== m_axis_tdata || exp_w.singular !== m_axis_tuser ||
                    exp_w.last !== m_axis_tlast) begin
                    $display("%0t: expected %h/%b/%b actual %h/%b/%b", $time,
                             exp_w.value, exp_w.singular, exp_w.last,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_identity();
        logic [31:0] m [16];
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h00010000 : 32'h0;
        send_matrix(m);
    endtask

    // duplicate columns of extreme values: determinant zero
    task automatic test_singular();
        logic [31:0] m [16];
        for (int i = 0; i < 16; i++) m[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
        send_matrix(m);
    endtask

    // tiny and huge diagonal: saturation in both directions
    task automatic test_saturation();
        logic [31:0] m [16];
        for (int i = 0; i < 16; i++) m[i] = '0;
        m[0] = 32'h00000001; m[5] = 32'hffffffff; m[10] = 32'h80000000; m[15] = 32'h7fffffff;
        send_matrix(m);
    endtask

    task automatic random_matrix(output logic [31:0] m [16]);
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 16; i++) begin
            if (kind < 4) m[i] = $urandom;
            else if (kind < 8) m[i] = $urandom_range(0, 32'h3ffff) - 32'h20000;
            else m[i] = $urandom_range(0, 32'h7ff) - 32'h400;
        end
        if (kind == 9) begin
            for (int i = 0; i < 4; i++) m[12 + i] = m[4 + i];
        end
    endtask

    task automatic test_backpressure();
        logic [31:0] m [16];
        hold_req++;
        for (int n = 0; n < 2; n++) begin
            random_matrix(m);
            send_matrix(m);
        end
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic [31:0] m [16];
        for (int n = 0; n < count; n++) begin
            random_matrix(m);
            send_matrix(m);
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        quiet = 1'b1;
        test_identity();
        quiet = 1'b0;
        test_singular();
        test_saturation();
        wait_drained();
        test_backpressure();
        test_random(12);
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && inverse_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
